// ----- hdl/lqrisf_pkg.sv -----
// Shared types, widths and constants of the LQR servo with integral action.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lqrisf_pkg;

  localparam int unsigned N_STATES      = 6;
  localparam int unsigned N_DRIVES      = 4;
  localparam int unsigned N_REFS        = 3;
  localparam int unsigned N_TERMS       = N_STATES + N_REFS;
  localparam int unsigned N_GAINS       = N_DRIVES * N_TERMS;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned PROD_W    = DATA_W + ERR_W;
  localparam int unsigned TERM_W    = $clog2(N_TERMS);
  localparam int unsigned ACC_GUARD = $clog2(N_TERMS + 1);
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned LANE_W    = $clog2(N_DRIVES);
  localparam int unsigned REF_W     = $clog2(N_REFS);

  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned PERIOD_FRAC = 16;
  localparam int unsigned IPROD_W     = PERIOD_W + 1 + ERR_W;
  localparam int unsigned ISTEP_W     = IPROD_W - PERIOD_FRAC;
  localparam int unsigned ISUM_W      = ISTEP_W + 1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd655;

  localparam int unsigned N_CFG       = 8;
  localparam int unsigned APB_ADDR_W  = $clog2(N_CFG) + 2;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 232;
  localparam int unsigned OUT_TDATA_W = N_DRIVES * DATA_W;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_REF1, REG_REF2, REG_REF3, REG_TRIM_F1,
    REG_TRIM_F2, REG_TRIM_A1, REG_TRIM_A2, REG_PERIOD
  } cfg_reg_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_GAIN   = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ERR, ST_INT_MUL, ST_INT_ADD, ST_MAC, ST_DRAIN, ST_MERGE
  } state_e;

  typedef logic [N_REFS-1:0][ERR_W-1:0]  err_vec_t;
  typedef logic [N_REFS-1:0][DATA_W-1:0] data_vec_t;

  typedef struct packed {
    logic              start;
    logic              mul_en;
    logic [TERM_W-1:0] term;
  } lane_ctrl_t;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic [DATA_W-1:0] value;
  } gain_wr_t;

  typedef struct packed {
    logic mul_en;
    logic upd_en;
  } integ_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
    logic [TERM_W-1:0] term;
  } gain_dec_t;

  // Global table slot of term k of drive r: state gains row-major, then integral gains.
  function automatic logic [IDX_W-1:0] gain_slot(int unsigned r, int unsigned k);
    if (k < N_STATES) begin
      return IDX_W'(r * N_STATES + k);
    end
    return IDX_W'(N_DRIVES * N_STATES + r * N_REFS + (k - N_STATES));
  endfunction

  // Map a gain slot to the lane and term that hold it; slots past the table miss.
  function automatic gain_dec_t gain_decode(logic [IDX_W-1:0] idx);
    gain_dec_t d;
    d = '0;
    for (int unsigned r = 0; r < N_DRIVES; r++) begin
      for (int unsigned k = 0; k < N_TERMS; k++) begin
        if (idx == gain_slot(r, k)) begin
          d.hit  = 1'b1;
          d.lane = LANE_W'(r);
          d.term = TERM_W'(k);
        end
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lqrisf_integ.sv -----
// Three joint integrators: period times error, floored, added and saturated.
// Depends on lqrisf_pkg.
`default_nettype none

module lqrisf_integ (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire lqrisf_pkg::integ_ctrl_t                ctrl_i,
  input  wire logic [lqrisf_pkg::PERIOD_W-1:0]        period_i,
  input  wire lqrisf_pkg::err_vec_t                   err_i,
  output lqrisf_pkg::data_vec_t                       integ_o,
  output logic                                        sat_o
);

  localparam int unsigned DW  = lqrisf_pkg::DATA_W;
  localparam int unsigned PW  = lqrisf_pkg::IPROD_W;
  localparam int unsigned STW = lqrisf_pkg::ISTEP_W;
  localparam int unsigned SW  = lqrisf_pkg::ISUM_W;
  localparam int unsigned NR  = lqrisf_pkg::N_REFS;

  logic signed [PW-1:0] prod_q [NR];
  lqrisf_pkg::data_vec_t integ_q, integ_d;
  logic [NR-1:0] clip;
  logic sat_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      for (int j = 0; j < NR; j++) begin
        prod_q[j] <= $signed({1'b0, period_i}) * $signed(err_i[j]);
      end
    end
  end

  always_comb begin
    logic [STW-1:0] step;
    logic [SW-1:0]  sum;
    integ_d = integ_q;
    clip    = '0;
    for (int j = 0; j < NR; j++) begin
      step = prod_q[j][PW-1:lqrisf_pkg::PERIOD_FRAC];
      sum  = {{(SW-DW){integ_q[j][DW-1]}}, integ_q[j]} + {{(SW-STW){step[STW-1]}}, step};
      if (!sum[SW-1] && (|sum[SW-2:DW-1])) begin
        integ_d[j] = lqrisf_pkg::SAT_MAX;
        clip[j]    = 1'b1;
      end else if (sum[SW-1] && !(&sum[SW-2:DW-1])) begin
        integ_d[j] = lqrisf_pkg::SAT_MIN;
        clip[j]    = 1'b1;
      end else begin
        integ_d[j] = sum[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      sat_q   <= 1'b0;
    end else if (ctrl_i.upd_en) begin
      integ_q <= integ_d;
      sat_q   <= |clip;
    end
  end

  assign integ_o = integ_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

// ----- hdl/lqrisf_lane.sv -----
// One drive lane: its nine gains, one multiplier and a running accumulator.
// Depends on lqrisf_pkg.
`default_nettype none

module lqrisf_lane #(
  parameter  int unsigned FRAC_BITS = lqrisf_pkg::FRAC_BITS_DEF,
  localparam int unsigned ACC_W     = lqrisf_pkg::PROD_W - FRAC_BITS + lqrisf_pkg::ACC_GUARD
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              gain_we_i,
  input  wire lqrisf_pkg::gain_wr_t              gain_wr_i,
  input  wire lqrisf_pkg::lane_ctrl_t            ctrl_i,
  input  wire logic [lqrisf_pkg::ERR_W-1:0]      op_i,
  input  wire logic [lqrisf_pkg::DATA_W-1:0]     trim_i,
  output logic [ACC_W-1:0]                       acc_o
);

  localparam int unsigned DW  = lqrisf_pkg::DATA_W;
  localparam int unsigned PW  = lqrisf_pkg::PROD_W;
  localparam int unsigned SHW = PW - FRAC_BITS;

  logic signed [DW-1:0] gain_q [lqrisf_pkg::N_TERMS];
  logic signed [PW-1:0] prod_q;
  logic                 prod_vld_q;
  logic [ACC_W-1:0]     acc_q;
  logic [SHW-1:0]       shifted;

  always_ff @(posedge clk_i) begin
    if (gain_we_i) begin
      gain_q[gain_wr_i.term] <= gain_wr_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= gain_q[ctrl_i.term] * $signed(op_i);
    end
  end

  // Floor by arithmetic shift: drop the fraction of the exact product.
  assign shifted = prod_q[PW-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= {{(ACC_W-DW){trim_i[DW-1]}}, trim_i};
    end else if (prod_vld_q) begin
      acc_q <= acc_q - {{(ACC_W-SHW){shifted[SHW-1]}}, shifted};
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- hdl/lqrisf_merge.sv -----
// Merging stage: saturates the lane sums, folds in the flag, holds the result.
// Depends on lqrisf_pkg.
`default_nettype none

module lqrisf_merge #(
  parameter  int unsigned FRAC_BITS = lqrisf_pkg::FRAC_BITS_DEF,
  localparam int unsigned ACC_W     = lqrisf_pkg::PROD_W - FRAC_BITS + lqrisf_pkg::ACC_GUARD
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        load_i,
  input  wire logic [lqrisf_pkg::N_DRIVES-1:0][ACC_W-1:0]  acc_i,
  input  wire logic                                        integ_sat_i,
  output logic                                             free_o,
  input  wire logic                                        m_axis_tready,
  output logic                                             m_axis_tvalid,
  output logic [lqrisf_pkg::OUT_TDATA_W-1:0]               m_axis_tdata,
  output logic                                             m_axis_tuser
);

  localparam int unsigned DW = lqrisf_pkg::DATA_W;
  localparam int unsigned ND = lqrisf_pkg::N_DRIVES;

  logic [ND-1:0][DW-1:0] drive_d;
  logic [ND-1:0]         clip;
  logic [lqrisf_pkg::OUT_TDATA_W-1:0] data_q;
  logic                  sat_q;
  logic                  vld_q;

  always_comb begin
    for (int r = 0; r < ND; r++) begin
      clip[r] = 1'b1;
      if (!acc_i[r][ACC_W-1] && (|acc_i[r][ACC_W-2:DW-1])) begin
        drive_d[r] = lqrisf_pkg::SAT_MAX;
      end else if (acc_i[r][ACC_W-1] && !(&acc_i[r][ACC_W-2:DW-1])) begin
        drive_d[r] = lqrisf_pkg::SAT_MIN;
      end else begin
        drive_d[r] = acc_i[r][DW-1:0];
        clip[r]    = 1'b0;
      end
    end
  end

  assign free_o = !vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= drive_d;
      sat_q  <= integ_sat_i || (|clip);
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = sat_q;

endmodule

`default_nettype wire

// ----- hdl/lqr_integral_state_feedback.sv -----
// Top level of the LQR servo with integral action: config registers, sequencer,
// integrators, four drive lanes and the merging stage. Depends on lqrisf_pkg.
`default_nettype none

// A control sample request updates the three joint integrators and produces four
// saturated drive commands plus a clip flag; a gain write request stores one of the
// 36 gains and produces no result. A sample occupies the block through the error,
// integrator multiply and update steps, nine multiply-accumulate steps in each drive
// lane, drain and merge; merge waits while the output still holds an untaken result,
// and no request is taken until the block is idle again. A gain write leaves the block
// idle. The result waits in an output register while the next request is accepted.
// Gains are undefined until written and must be loaded before use. The user must write
// registers over APB only while the block is idle; the block does not enforce it.
module lqr_integral_state_feedback #(
  parameter  int unsigned FRAC_BITS = lqrisf_pkg::FRAC_BITS_DEF,
  localparam int unsigned ACC_W     = lqrisf_pkg::PROD_W - FRAC_BITS + lqrisf_pkg::ACC_GUARD
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // angle_1, angle_2, angle_3, rate_1, rate_2, rate_3, gain_index, gain_value, 2 pad bits
  input  wire logic [lqrisf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type
  input  wire logic                                  s_axis_tuser,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // drive_0, drive_1, drive_2, drive_3
  output logic [lqrisf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // saturated
  output logic                                       m_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lqrisf_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lqrisf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lqrisf_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                       pready
);

  localparam int unsigned DW   = lqrisf_pkg::DATA_W;
  localparam int unsigned EW   = lqrisf_pkg::ERR_W;
  localparam int unsigned NR   = lqrisf_pkg::N_REFS;
  localparam int unsigned ND   = lqrisf_pkg::N_DRIVES;
  localparam int unsigned TW   = lqrisf_pkg::TERM_W;
  localparam int unsigned RW   = lqrisf_pkg::REF_W;
  localparam int unsigned IXW  = lqrisf_pkg::IDX_W;
  localparam int unsigned RATE_LO = NR * DW;
  localparam int unsigned IDX_LO  = 2 * NR * DW;
  localparam int unsigned GVAL_LO = IDX_LO + IXW;

  // ---------------------------------------------------------------- config
  logic [NR-1:0][DW-1:0]               ref_q;
  logic [ND-1:0][DW-1:0]               trim_q;
  logic [lqrisf_pkg::PERIOD_W-1:0]     period_q;
  logic                                cfg_we;
  lqrisf_pkg::cfg_reg_e                cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = lqrisf_pkg::cfg_reg_e'(paddr[lqrisf_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      trim_q   <= '0;
      period_q <= lqrisf_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_sel)
        lqrisf_pkg::REG_REF1:    ref_q[0]  <= pwdata;
        lqrisf_pkg::REG_REF2:    ref_q[1]  <= pwdata;
        lqrisf_pkg::REG_REF3:    ref_q[2]  <= pwdata;
        lqrisf_pkg::REG_TRIM_F1: trim_q[0] <= pwdata;
        lqrisf_pkg::REG_TRIM_F2: trim_q[1] <= pwdata;
        lqrisf_pkg::REG_TRIM_A1: trim_q[2] <= pwdata;
        lqrisf_pkg::REG_TRIM_A2: trim_q[3] <= pwdata;
        lqrisf_pkg::REG_PERIOD:  period_q  <= pwdata[lqrisf_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      lqrisf_pkg::REG_REF1:    prdata = ref_q[0];
      lqrisf_pkg::REG_REF2:    prdata = ref_q[1];
      lqrisf_pkg::REG_REF3:    prdata = ref_q[2];
      lqrisf_pkg::REG_TRIM_F1: prdata = trim_q[0];
      lqrisf_pkg::REG_TRIM_F2: prdata = trim_q[1];
      lqrisf_pkg::REG_TRIM_A1: prdata = trim_q[2];
      lqrisf_pkg::REG_TRIM_A2: prdata = trim_q[3];
      lqrisf_pkg::REG_PERIOD:
        prdata = {{(lqrisf_pkg::APB_DATA_W-lqrisf_pkg::PERIOD_W){1'b0}}, period_q};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- intake
  logic                    in_acc, smp_acc, gain_acc;
  lqrisf_pkg::gain_dec_t   gdec;
  lqrisf_pkg::gain_wr_t    gain_wr;
  lqrisf_pkg::data_vec_t   angle_q, rate_q;
  lqrisf_pkg::err_vec_t    err_q, err_d;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign smp_acc  = in_acc && (s_axis_tuser == lqrisf_pkg::REQ_SAMPLE);
  assign gain_acc = in_acc && (s_axis_tuser == lqrisf_pkg::REQ_GAIN);
  assign gdec     = lqrisf_pkg::gain_decode(s_axis_tdata[GVAL_LO-1:IDX_LO]);
  assign gain_wr.term  = gdec.term;
  assign gain_wr.value = s_axis_tdata[GVAL_LO+DW-1:GVAL_LO];

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      angle_q <= s_axis_tdata[RATE_LO-1:0];
      rate_q  <= s_axis_tdata[IDX_LO-1:RATE_LO];
    end
  end

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      err_d[j] = {angle_q[j][DW-1], angle_q[j]} - {ref_q[j][DW-1], ref_q[j]};
    end
  end

  // ---------------------------------------------------------------- sequencer
  lqrisf_pkg::state_e      state_q, state_d;
  logic [TW-1:0]           term_q, term_d;
  logic                    err_load;
  logic                    merge_load, merge_free;
  lqrisf_pkg::lane_ctrl_t  lane_ctrl;
  lqrisf_pkg::integ_ctrl_t integ_ctrl;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lqrisf_pkg::ST_IDLE:    if (smp_acc) state_d = lqrisf_pkg::ST_ERR;
      lqrisf_pkg::ST_ERR:     state_d = lqrisf_pkg::ST_INT_MUL;
      lqrisf_pkg::ST_INT_MUL: state_d = lqrisf_pkg::ST_INT_ADD;
      lqrisf_pkg::ST_INT_ADD: state_d = lqrisf_pkg::ST_MAC;
      lqrisf_pkg::ST_MAC: begin
        if (term_q == TW'(lqrisf_pkg::N_TERMS - 1)) state_d = lqrisf_pkg::ST_DRAIN;
      end
      lqrisf_pkg::ST_DRAIN:   state_d = lqrisf_pkg::ST_MERGE;
      lqrisf_pkg::ST_MERGE:   if (merge_free) state_d = lqrisf_pkg::ST_IDLE;
      default:                state_d = lqrisf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready     = 1'b0;
    err_load          = 1'b0;
    integ_ctrl        = '0;
    lane_ctrl.start   = 1'b0;
    lane_ctrl.mul_en  = 1'b0;
    lane_ctrl.term    = term_q;
    merge_load        = 1'b0;
    term_d            = term_q;
    case (state_q)
      lqrisf_pkg::ST_IDLE:    s_axis_tready = 1'b1;
      lqrisf_pkg::ST_ERR: begin
        err_load        = 1'b1;
        lane_ctrl.start = 1'b1;
      end
      lqrisf_pkg::ST_INT_MUL: integ_ctrl.mul_en = 1'b1;
      lqrisf_pkg::ST_INT_ADD: begin
        integ_ctrl.upd_en = 1'b1;
        term_d            = '0;
      end
      lqrisf_pkg::ST_MAC: begin
        lane_ctrl.mul_en = 1'b1;
        term_d           = term_q + TW'(1);
      end
      lqrisf_pkg::ST_MERGE:   merge_load = merge_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lqrisf_pkg::ST_IDLE;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_load) begin
      err_q <= err_d;
    end
  end

  // ---------------------------------------------------------------- integrators
  lqrisf_pkg::data_vec_t integ;
  logic                  integ_sat;

  lqrisf_integ u_integ (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (integ_ctrl),
    .period_i (period_q),
    .err_i    (err_q),
    .integ_o  (integ),
    .sat_o    (integ_sat)
  );

  // Broadcast operand: errors, then rates, then the updated integrators.
  logic [EW-1:0] op;
  logic [TW-1:0] t_rate, t_int;

  assign t_rate = term_q - TW'(NR);
  assign t_int  = term_q - TW'(2 * NR);

  always_comb begin
    if (term_q < TW'(NR)) begin
      op = err_q[term_q[RW-1:0]];
    end else if (term_q < TW'(2 * NR)) begin
      op = {rate_q[t_rate[RW-1:0]][DW-1], rate_q[t_rate[RW-1:0]]};
    end else begin
      op = {integ[t_int[RW-1:0]][DW-1], integ[t_int[RW-1:0]]};
    end
  end

  // ---------------------------------------------------------------- lanes
  logic [ND-1:0][ACC_W-1:0] acc;

  for (genvar r = 0; r < ND; r++) begin : g_lane
    lqrisf_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .gain_we_i (gain_acc && gdec.hit && (gdec.lane == lqrisf_pkg::LANE_W'(r))),
      .gain_wr_i (gain_wr),
      .ctrl_i    (lane_ctrl),
      .op_i      (op),
      .trim_i    (trim_q[r]),
      .acc_o     (acc[r])
    );
  end

  lqrisf_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (merge_load),
    .acc_i         (acc),
    .integ_sat_i   (integ_sat),
    .free_o        (merge_free),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_result_from_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == lqrisf_pkg::ST_MERGE))
    else $error("result raised outside the merge step");

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lqrisf_pkg::ST_INT_ADD) |=> $stable(integ))
    else $error("integrator changed outside its update step");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lqrisf_pkg::ST_MAC) |-> (term_q < TW'(lqrisf_pkg::N_TERMS)))
    else $error("term counter past the last gain");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/lqr_integral_state_feedback_checker.sv -----
// Scoreboard for the LQR servo with integral action: watches the request,
// result and APB channels, predicts every drive command and compares.
// Depends on lqrisf_pkg.
`default_nettype none

module lqr_integral_state_feedback_checker
  import lqrisf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // angle_1, angle_2, angle_3, rate_1, rate_2, rate_3, gain_index, gain_value, 2 pad bits
  input  wire logic [IN_TDATA_W-1:0]   s_tdata_i,
  // req_type
  input  wire logic                    s_tuser_i,
  input  wire logic                    s_tvalid_i,
  input  wire logic                    s_tready_i,
  // drive_0, drive_1, drive_2, drive_3
  input  wire logic [OUT_TDATA_W-1:0]  m_tdata_i,
  // saturated
  input  wire logic                    m_tuser_i,
  input  wire logic                    m_tvalid_i,
  input  wire logic                    m_tready_i,
  input  wire logic                    psel_i,
  input  wire logic                    penable_i,
  input  wire logic                    pwrite_i,
  input  wire logic [APB_ADDR_W-1:0]   paddr_i,
  input  wire logic [APB_DATA_W-1:0]   pwdata_i,
  input  wire logic [APB_DATA_W-1:0]   prdata_i,
  input  wire logic                    pready_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int unsigned ANG_LSB  = 0;
  localparam int unsigned RATE_LSB = N_REFS * DATA_W;
  localparam int unsigned GIDX_LSB = 2 * N_REFS * DATA_W;
  localparam int unsigned GVAL_LSB = GIDX_LSB + IDX_W;
  localparam int unsigned MAX_SHOWN = 10;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [79:0]       wide_t;

  typedef struct packed {
    logic [N_DRIVES-1:0][DATA_W-1:0] drive;
    logic                            clipped;
  } drive_cmd_t;

  localparam wide_t Q_MAX = 80'sd2147483647;
  localparam wide_t Q_MIN = -80'sd2147483648;

  q_t                  ref_angle [N_REFS];
  q_t                  trim_ofs  [N_DRIVES];
  logic [PERIOD_W-1:0] period;
  q_t                  gain_mem  [N_GAINS];
  q_t                  integ     [N_REFS];
  drive_cmd_t          pending_drives[$];
  int                  miss_cnt;

  function automatic q_t clip32(input wide_t v, inout logic hit);
    if (v > Q_MAX) begin
      hit = 1'b1;
      return Q_MAX[DATA_W-1:0];
    end
    if (v < Q_MIN) begin
      hit = 1'b1;
      return Q_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // Advance the integrators and form the four drive commands of one sample.
  function automatic drive_cmd_t predict_drives(input logic [IN_TDATA_W-1:0] td);
    drive_cmd_t res;
    wide_t      err  [N_REFS];
    wide_t      rate [N_REFS];
    wide_t      acc;
    wide_t      w;
    q_t         a;
    logic       hit;
    hit = 1'b0;
    for (int j = 0; j < N_REFS; j++) begin
      a       = td[ANG_LSB + DATA_W*j +: DATA_W];
      err[j]  = a;
      err[j]  = err[j] - ref_angle[j];
      a       = td[RATE_LSB + DATA_W*j +: DATA_W];
      rate[j] = a;
      w       = integ[j];
      w       = w + ((err[j] * $signed({1'b0, period})) >>> PERIOD_FRAC);
      integ[j] = clip32(w, hit);
    end
    for (int r = 0; r < N_DRIVES; r++) begin
      acc = trim_ofs[r];
      for (int j = 0; j < N_REFS; j++) begin
        acc = acc - ((gain_mem[r*N_STATES + j] * err[j]) >>> FRAC_BITS_DEF);
        acc = acc - ((gain_mem[r*N_STATES + N_REFS + j] * rate[j]) >>> FRAC_BITS_DEF);
        acc = acc - ((gain_mem[N_DRIVES*N_STATES + r*N_REFS + j] * integ[j])
                     >>> FRAC_BITS_DEF);
      end
      res.drive[r] = clip32(acc, hit);
    end
    res.clipped = hit;
    return res;
  endfunction

  task automatic note_miss(input string what, input logic [31:0] want,
                           input logic [31:0] seen);
    miss_cnt++;
    if (miss_cnt <= MAX_SHOWN) begin
      $display("mismatch on %s: expected %h, got %h", what, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_cmd_t            seen;
    drive_cmd_t            want;
    logic [APB_DATA_W-1:0] rd_want;
    logic [IDX_W-1:0]      slot;
    if (!rst_ni) begin
      for (int j = 0; j < N_REFS; j++) begin
        ref_angle[j] = '0;
        integ[j]     = '0;
      end
      for (int r = 0; r < N_DRIVES; r++) begin
        trim_ofs[r] = '0;
      end
      for (int i = 0; i < N_GAINS; i++) begin
        gain_mem[i] = '0;
      end
      period = PERIOD_RESET;
      pending_drives.delete();
      miss_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (cfg_reg_e'(paddr_i[APB_ADDR_W-1:2]))
            REG_REF1:    ref_angle[0] = pwdata_i;
            REG_REF2:    ref_angle[1] = pwdata_i;
            REG_REF3:    ref_angle[2] = pwdata_i;
            REG_TRIM_F1: trim_ofs[0]  = pwdata_i;
            REG_TRIM_F2: trim_ofs[1]  = pwdata_i;
            REG_TRIM_A1: trim_ofs[2]  = pwdata_i;
            REG_TRIM_A2: trim_ofs[3]  = pwdata_i;
            REG_PERIOD:  period       = pwdata_i[PERIOD_W-1:0];
            default: ;
          endcase
        end else begin
          case (cfg_reg_e'(paddr_i[APB_ADDR_W-1:2]))
            REG_REF1:    rd_want = ref_angle[0];
            REG_REF2:    rd_want = ref_angle[1];
            REG_REF3:    rd_want = ref_angle[2];
            REG_TRIM_F1: rd_want = trim_ofs[0];
            REG_TRIM_F2: rd_want = trim_ofs[1];
            REG_TRIM_A1: rd_want = trim_ofs[2];
            REG_TRIM_A2: rd_want = trim_ofs[3];
            default:     rd_want = {{(APB_DATA_W-PERIOD_W){1'b0}}, period};
          endcase
          if (prdata_i !== rd_want) begin
            note_miss("register read", rd_want, prdata_i);
          end
        end
      end

      if (m_tvalid_i && m_tready_i) begin
        seen = {m_tdata_i, m_tuser_i};
        if (pending_drives.size() == 0) begin
          note_miss("result with no sample waiting", '0, m_tdata_i[DATA_W-1:0]);
        end else begin
          want = pending_drives.pop_front();
          for (int r = 0; r < N_DRIVES; r++) begin
            if (seen.drive[r] !== want.drive[r]) begin
              note_miss($sformatf("drive_%0d", r), want.drive[r], seen.drive[r]);
            end
          end
          if (seen.clipped !== want.clipped) begin
            note_miss("saturated", 32'(want.clipped), 32'(seen.clipped));
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == REQ_GAIN) begin
          slot = s_tdata_i[GIDX_LSB +: IDX_W];
          // Drop writes to slots past the table.
          if (slot < N_GAINS) begin
            gain_mem[slot] = s_tdata_i[GVAL_LSB +: DATA_W];
          end
        end else begin
          pending_drives.push_back(predict_drives(s_tdata_i));
        end
      end

      fail_count_o <= miss_cnt;
      pending_o    <= pending_drives.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/lqr_integral_state_feedback_test.sv -----
// Testbench top of the LQR servo with integral action: clock, reset, APB register
// setup, request stimulus and result back-pressure, verdict.
// Depends on lqrisf_pkg, the block and lqr_integral_state_feedback_checker.
`default_nettype none

module lqr_integral_state_feedback_test;
  import lqrisf_pkg::*;

  localparam int unsigned ANG_LSB       = 0;
  localparam int unsigned RATE_LSB      = N_REFS * DATA_W;
  localparam int unsigned GIDX_LSB      = 2 * N_REFS * DATA_W;
  localparam int unsigned GVAL_LSB      = GIDX_LSB + IDX_W;
  localparam int unsigned N_STATE_GAINS = N_DRIVES * N_STATES;
  localparam int          N_PHASES      = 10;
  localparam int          PHASE_ITEMS   = 70;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          CYCLE_LIMIT   = 500_000;
  localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN         = 32'h8000_0000;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr    = '0;
  logic [APB_DATA_W-1:0]  pwdata   = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int fail_cnt;
  int pending;
  int cycles_run = 0;
  // 0: no idling, 1: gap on every request, 2: occasional gaps. [0] sender, [1] receiver.
  int idle_style[2] = '{1, 1};

  lqr_integral_state_feedback uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lqr_integral_state_feedback_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_cnt),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_gap(input int side);
    case (idle_style[side])
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Signed value in [-2^(mag-1), 2^(mag-1)-1], with a few corners and raw words mixed in.
  function automatic logic [31:0] pick_value(input int unsigned mag);
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 3))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1:       return raw;
      default: return $signed(raw) >>> (32 - mag);
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] noise_fill();
    logic [255:0] fill;
    for (int k = 0; k < 8; k++) begin
      fill[32*k +: 32] = $urandom;
    end
    return fill[IN_TDATA_W-1:0];
  endfunction

  task automatic apb_access(input logic wr, input cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_req(input req_type_e kind, input logic [IN_TDATA_W-1:0] td);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= td;
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_gain(input logic [IDX_W-1:0] idx, input logic [31:0] v);
    logic [IN_TDATA_W-1:0] td;
    td = noise_fill();
    td[GIDX_LSB +: IDX_W]  = idx;
    td[GVAL_LSB +: DATA_W] = v;
    send_req(REQ_GAIN, td);
  endtask

  task automatic send_sample(input data_vec_t ang, input data_vec_t rt);
    logic [IN_TDATA_W-1:0] td;
    td = noise_fill();
    for (int j = 0; j < N_REFS; j++) begin
      td[ANG_LSB + DATA_W*j +: DATA_W]  = ang[j];
      td[RATE_LSB + DATA_W*j +: DATA_W] = rt[j];
    end
    send_req(REQ_SAMPLE, td);
  endtask

  task automatic load_gains(input int unsigned mag_k, input int unsigned mag_ki);
    for (int i = 0; i < N_GAINS; i++) begin
      send_gain(IDX_W'(i), pick_value(i < N_STATE_GAINS ? mag_k : mag_ki));
    end
  endtask

  // Hold off until every result is out and the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    @(posedge clk_i);
    forever begin
      int gap;
      gap = draw_gap(1);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  initial begin
    logic [N_CFG-1:0][31:0] cfg_vals;
    data_vec_t              ang;
    data_vec_t              rt;
    int unsigned            mag_a;
    int unsigned            mag_k;
    int unsigned            mag_ki;
    int                     pick;

    @(posedge rst_ni);
    @(posedge clk_i);

    // Reset register values: zero refs and trims, default period.
    load_gains(17, 12);
    send_sample('0, '0);
    send_sample({3{Q_MAX}}, {3{Q_MAX}});
    send_sample({3{Q_MIN}}, {3{Q_MIN}});
    send_sample({3{Q_MAX}}, {3{Q_MIN}});
    send_sample({Q_MIN, 32'h0000_0000, Q_MAX}, {32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001});
    send_gain(IDX_W'(0), Q_MIN);
    send_gain(IDX_W'(N_STATE_GAINS - 1), Q_MAX);
    send_gain(IDX_W'(N_STATE_GAINS), Q_MIN);
    send_gain(IDX_W'(N_GAINS - 1), Q_MAX);
    send_sample({3{Q_MIN}}, {3{Q_MAX}});
    // Writes past the table must leave the gains alone.
    send_gain(IDX_W'(N_GAINS), 32'h1234_5678);
    send_gain('1, 32'hFFFF_FFFF);
    send_sample({3{Q_MAX}}, '0);
    send_sample({32'h0000_8000, 32'hFFFF_8000, 32'h0000_0000}, {3{32'hFFFF_FFFF}});

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      if (p % 3 == 0) begin
        mag_a  = 31;
        mag_k  = 31;
        mag_ki = 31;
      end else begin
        mag_a  = 20;
        mag_k  = 17;
        mag_ki = 12;
      end
      case (p)
        0: begin
          for (int i = REG_REF1; i <= REG_TRIM_A2; i++) cfg_vals[i] = Q_MAX;
          cfg_vals[REG_PERIOD] = 32'h0000_FFFF;
        end
        1: begin
          for (int i = REG_REF1; i <= REG_TRIM_A2; i++) cfg_vals[i] = Q_MIN;
          cfg_vals[REG_PERIOD] = '0;
        end
        2: begin
          for (int i = REG_REF1; i <= REG_TRIM_A2; i++) cfg_vals[i] = '0;
          cfg_vals[REG_PERIOD] = 32'd1;
        end
        default: begin
          for (int i = REG_REF1; i <= REG_TRIM_A2; i++) cfg_vals[i] = pick_value(mag_a);
          case ($urandom_range(0, 4))
            0:       cfg_vals[REG_PERIOD] = 32'd655;
            1:       cfg_vals[REG_PERIOD] = '0;
            2:       cfg_vals[REG_PERIOD] = 32'h0000_FFFF;
            3:       cfg_vals[REG_PERIOD] = 32'd1;
            default: cfg_vals[REG_PERIOD] = {16'h0000, 16'($urandom)};
          endcase
        end
      endcase
      for (int i = 0; i < N_CFG; i++) apb_access(1'b1, cfg_reg_e'(i), cfg_vals[i]);
      for (int i = 0; i < N_CFG; i++) apb_access(1'b0, cfg_reg_e'(i), '0);

      load_gains(mag_k, mag_ki);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 29) == 0) idle_style[$urandom_range(0, 1)] = $urandom_range(0, 2);
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
          for (int j = 0; j < N_REFS; j++) begin
            ang[j] = pick_value(mag_a);
            rt[j]  = pick_value(mag_a);
          end
          send_sample(ang, rt);
        end else if (pick < 94) begin
          send_gain(IDX_W'($urandom_range(0, N_GAINS - 1)), pick_value(mag_k));
        end else begin
          send_gain(IDX_W'($urandom_range(N_GAINS, 63)), $urandom);
        end
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/lqrisf_pkg.sv
hdl/lqrisf_integ.sv
hdl/lqrisf_lane.sv
hdl/lqrisf_merge.sv
hdl/lqr_integral_state_feedback.sv
tb/sv/lqr_integral_state_feedback_checker.sv
tb/sv/lqr_integral_state_feedback_test.sv
